// ===== sv/emc_pkg.sv =====
// Shared types and codes for the exact-match cache with aging.
// Holds the operation and status codes and the channel payload structs.
// No dependencies.
package emc_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned KeyW    = 64;
  localparam int unsigned DataW   = 32;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned RemW    = 7;
  localparam int unsigned ExpW    = 31;
  localparam logic [ExpW-1:0] ExpReset = ExpW'(60);

  typedef enum logic [KindW-1:0] {
    OP_LOOKUP     = 2'd0,
    OP_INSERT     = 2'd1,
    OP_PURGE      = 2'd2,
    OP_INVALIDATE = 2'd3
  } op_kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_HIT         = 3'd0,
    ST_MISS        = 3'd1,
    ST_INSERTED    = 3'd2,
    ST_FULL        = 3'd3,
    ST_PURGED      = 3'd4,
    ST_INVALIDATED = 3'd5
  } status_e;

  typedef struct packed {
    op_kind_e               kind;
    logic [KeyW-1:0]        key;
    logic [DataW-1:0]       data_in;
    logic [TimeW-1:0]       current_time;
  } req_item_t;

  typedef struct packed {
    status_e                status;
    logic [DataW-1:0]       data_out;
    logic [RemW-1:0]        removed_count;
  } rsp_item_t;

  typedef struct packed {
    logic [ExpW-1:0]        expire_seconds;
  } cfg_item_t;

endpackage

// ===== sv/emc_stream_if.sv =====
// Valid/ready channel used for requests, responses and configuration.
// The payload type is a parameter; no other dependencies.
interface emc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/exact_match_cache_with_aging.sv =====
// Exact-match cache with aging. A table of ENTRIES slots, each a valid bit,
// a key, a data word and a last-access stamp, kept in memories with one
// write port and one registered read. Every operation is one request transfer and
// one response transfer. Lookup and purge walk the table one slot per cycle
// through a shared compare unit (key equality, or age = now - stamp against
// expire_seconds); each slot is compared in the cycle after its read is
// issued. A lookup stops early on a hit; a purge always walks every slot.
// Insert walks the valid bits for the lowest free slot; a full table or an
// invalidate goes straight to the response. Duplicate keys
// resolve to the lowest slot. The request side is ready only between
// operations, but a finished response may still wait in the output register
// while the next request is taken. expire_seconds may be written at any time
// the block is idle; it resets to 60.
module exact_match_cache_with_aging
  import emc_pkg::*;
#(
  parameter int unsigned ENTRIES  = 64,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  emc_stream_if.sink                req_i,
  emc_stream_if.source              rsp_o,
  emc_stream_if.sink                cfg_i
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e              state_q, state_d;
  op_kind_e            kind_q, kind_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [DataW-1:0]    din_q, din_d;
  logic [TimeW-1:0]    now_q, now_d;
  logic [ExpW-1:0]     exp_q, exp_d;
  logic [ENTRIES-1:0]  valid_q, valid_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [IdxW-1:0]     cmp_idx_q, cmp_idx_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic                issue_done_q, issue_done_d;
  logic [CntW-1:0]     removed_q, removed_d;
  status_e             res_status_q, res_status_d;
  logic [DataW-1:0]    res_data_q, res_data_d;
  logic                out_valid_q, out_valid_d;
  rsp_item_t           out_q, out_d;

  // store interface
  logic                entry_we, stamp_we;
  logic [IdxW-1:0]     wr_addr;
  logic [KEY_BITS-1:0] rd_key;
  logic [DataW-1:0]    rd_data;
  logic [TimeW-1:0]    rd_stamp;

  // shared compare unit
  logic [TimeW-1:0]    age;
  logic                slot_valid;
  logic                key_hit;
  logic                aged_out;

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  emc_entry_store #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_store (
    .clk_i      (clk_i),
    .rd_addr_i  (idx_q),
    .wr_addr_i  (wr_addr),
    .entry_we_i (entry_we),
    .stamp_we_i (stamp_we),
    .wr_key_i   (key_q),
    .wr_data_i  (din_q),
    .wr_stamp_i (now_q),
    .rd_key_o   (rd_key),
    .rd_data_o  (rd_data),
    .rd_stamp_o (rd_stamp)
  );

  // compare the slot read out last cycle
  assign slot_valid = valid_q[cmp_idx_q];
  assign age        = now_q - rd_stamp;
  assign key_hit    = slot_valid && (rd_key == key_q);
  assign aged_out   = slot_valid && (age > {1'b0, exp_q});

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    key_d        = key_q;
    din_d        = din_q;
    now_d        = now_q;
    exp_d        = exp_q;
    valid_d      = valid_q;
    count_d      = count_q;
    idx_d        = idx_q;
    cmp_idx_d    = cmp_idx_q;
    cmp_vld_d    = 1'b0;
    issue_done_d = issue_done_q;
    removed_d    = removed_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    entry_we     = 1'b0;
    stamp_we     = 1'b0;
    wr_addr      = idx_q;

    if (cfg_i.valid) begin
      exp_d = cfg_i.data.expire_seconds;
    end

    // drop the response once the sink takes it
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          kind_d       = req_i.data.kind;
          key_d        = req_i.data.key[KEY_BITS-1:0];
          din_d        = req_i.data.data_in;
          now_d        = req_i.data.current_time;
          idx_d        = '0;
          issue_done_d = 1'b0;
          removed_d    = '0;
          res_data_d   = '0;
          case (req_i.data.kind)
            OP_LOOKUP, OP_PURGE: begin
              state_d = S_SCAN;
            end
            OP_INSERT: begin
              if (count_q == FullCnt) begin
                res_status_d = ST_FULL;
                state_d      = S_FINISH;
              end else begin
                state_d = S_INSERT;
              end
            end
            default: begin
              valid_d      = '0;
              count_d      = '0;
              res_status_d = ST_INVALIDATED;
              state_d      = S_FINISH;
            end
          endcase
        end
      end

      S_INSERT: begin
        // a free slot exists, since the count is below capacity
        if (!valid_q[idx_q]) begin
          entry_we        = 1'b1;
          stamp_we        = 1'b1;
          valid_d[idx_q]  = 1'b1;
          count_d         = count_q + 1'b1;
          res_status_d    = ST_INSERTED;
          state_d         = S_FINISH;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_SCAN: begin
        // issue the next read
        if (!issue_done_q) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q;
          if (idx_q == LastIdx) begin
            issue_done_d = 1'b1;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        // evaluate the slot read last cycle
        if (cmp_vld_q) begin
          if (kind_q == OP_LOOKUP) begin
            if (key_hit) begin
              stamp_we     = 1'b1;
              wr_addr      = cmp_idx_q;
              res_status_d = ST_HIT;
              res_data_d   = rd_data;
              cmp_vld_d    = 1'b0;
              state_d      = S_FINISH;
            end else if (cmp_idx_q == LastIdx) begin
              res_status_d = ST_MISS;
              state_d      = S_FINISH;
            end
          end else begin
            if (aged_out) begin
              valid_d[cmp_idx_q] = 1'b0;
              count_d            = count_q - 1'b1;
              removed_d          = removed_q + 1'b1;
            end
            if (cmp_idx_q == LastIdx) begin
              res_status_d = ST_PURGED;
              state_d      = S_FINISH;
            end
          end
        end
      end

      S_FINISH: begin
        // hold until the output register is free
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d         = 1'b1;
          out_d.status        = res_status_q;
          out_d.data_out      = res_data_q;
          out_d.removed_count = RemW'(removed_q);
          state_d             = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      kind_q       <= OP_LOOKUP;
      key_q        <= '0;
      din_q        <= '0;
      now_q        <= '0;
      exp_q        <= ExpReset;
      valid_q      <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      cmp_idx_q    <= '0;
      cmp_vld_q    <= 1'b0;
      issue_done_q <= 1'b0;
      removed_q    <= '0;
      res_status_q <= ST_MISS;
      res_data_q   <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      kind_q       <= kind_d;
      key_q        <= key_d;
      din_q        <= din_d;
      now_q        <= now_d;
      exp_q        <= exp_d;
      valid_q      <= valid_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      cmp_idx_q    <= cmp_idx_d;
      cmp_vld_q    <= cmp_vld_d;
      issue_done_q <= issue_done_d;
      removed_q    <= removed_d;
      res_status_q <= res_status_d;
      res_data_q   <= res_data_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

endmodule

// ===== sv/emc_entry_store.sv =====
// Entry storage: key, data and stamp memories, one write port, one
// registered read port. Depends on emc_pkg.
module emc_entry_store
  import emc_pkg::*;
#(
  parameter int unsigned ENTRIES  = 64,
  parameter int unsigned KEY_BITS = 64,
  localparam int unsigned IdxW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                clk_i,
  input  logic [IdxW-1:0]     rd_addr_i,
  input  logic [IdxW-1:0]     wr_addr_i,
  input  logic                entry_we_i,
  input  logic                stamp_we_i,
  input  logic [KEY_BITS-1:0] wr_key_i,
  input  logic [DataW-1:0]    wr_data_i,
  input  logic [TimeW-1:0]    wr_stamp_i,
  output logic [KEY_BITS-1:0] rd_key_o,
  output logic [DataW-1:0]    rd_data_o,
  output logic [TimeW-1:0]    rd_stamp_o
);

  logic [KEY_BITS-1:0] key_mem   [ENTRIES];
  logic [DataW-1:0]    data_mem  [ENTRIES];
  logic [TimeW-1:0]    stamp_mem [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (entry_we_i) begin
      key_mem[wr_addr_i]  <= wr_key_i;
      data_mem[wr_addr_i] <= wr_data_i;
    end
    if (stamp_we_i) begin
      stamp_mem[wr_addr_i] <= wr_stamp_i;
    end
    rd_key_o   <= key_mem[rd_addr_i];
    rd_data_o  <= data_mem[rd_addr_i];
    rd_stamp_o <= stamp_mem[rd_addr_i];
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for exact_match_cache_with_aging.
// Depends on emc_pkg and emc_stream_if; predicts every response from its own
// copy of the table and checks each response transfer in order.
module testbench;
  import emc_pkg::*;

  localparam int unsigned Entries    = 64;
  localparam int unsigned StallLimit = 4000;   // cycles without any transfer
  localparam int unsigned PoolDepth  = 48;

  logic clk;
  logic rst_n;

  emc_stream_if #(.T(req_item_t)) req_if ();
  emc_stream_if #(.T(rsp_item_t)) rsp_if ();
  emc_stream_if #(.T(cfg_item_t)) cfg_if ();

  exact_match_cache_with_aging #(
    .ENTRIES  (Entries),
    .KEY_BITS (KeyW)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // Shadow copy of the table, the entry count and the expiry register.
  bit              slot_valid [Entries];
  logic [KeyW-1:0]  slot_key   [Entries];
  logic [DataW-1:0] slot_data  [Entries];
  logic [TimeW-1:0] slot_stamp [Entries];
  int unsigned     slot_count;
  logic [ExpW-1:0]  expiry_limit;

  rsp_item_t        pending_rsp [$];   // predicted responses, oldest first
  logic [KeyW-1:0]  live_keys [$];     // recently inserted keys, to aim lookups
  logic [TimeW-1:0] now_s;             // running time stamp of the stimulus
  int unsigned      error_count;
  int unsigned      sender_idle_pct;
  int unsigned      recv_stall_pct;
  rsp_item_t        rsp_seen;
  rsp_item_t        rsp_want;

  // Clock: 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Response sink: stall at random with the rate of the current phase.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run when no transfer happens on any channel for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (cfg_if.valid && cfg_if.ready) || !rst_n) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: watchdog expired with %0d responses outstanding", $time,
             pending_rsp.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Compute the response of one request and update the shadow table.
  // Lookup returns the lowest matching slot and refreshes its stamp; insert
  // takes the lowest free slot; purge drops slots whose wrapped age exceeds
  // the expiry; invalidate drops everything.
  function automatic rsp_item_t cache_predict(req_item_t req);
    rsp_item_t   res;
    int unsigned removed;
    logic [TimeW-1:0] age;
    int          i;
    res.status        = ST_MISS;
    res.data_out      = '0;
    res.removed_count = '0;
    removed           = 0;
    case (req.kind)
      OP_LOOKUP: begin
        for (i = 0; i < Entries; i++) begin
          if (slot_valid[i] && slot_key[i] == req.key) begin
            slot_stamp[i] = req.current_time;
            res.data_out  = slot_data[i];
            res.status    = ST_HIT;
            break;
          end
        end
      end
      OP_INSERT: begin
        res.status = ST_FULL;
        if (slot_count < Entries) begin
          for (i = 0; i < Entries; i++) begin
            if (!slot_valid[i]) begin
              slot_valid[i] = 1'b1;
              slot_key[i]   = req.key;
              slot_data[i]  = req.data_in;
              slot_stamp[i] = req.current_time;
              slot_count++;
              res.status = ST_INSERTED;
              break;
            end
          end
        end
      end
      OP_PURGE: begin
        for (i = 0; i < Entries; i++) begin
          age = req.current_time - slot_stamp[i];
          if (slot_valid[i] && age > {1'b0, expiry_limit}) begin
            slot_valid[i] = 1'b0;
            removed++;
          end
        end
        slot_count        = slot_count - removed;
        res.status        = ST_PURGED;
        res.removed_count = removed[RemW-1:0];
      end
      default: begin
        for (i = 0; i < Entries; i++) slot_valid[i] = 1'b0;
        slot_count = 0;
        res.status = ST_INVALIDATED;
      end
    endcase
    return res;
  endfunction

  function automatic req_item_t make_item(op_kind_e kind, logic [KeyW-1:0] key,
                                          logic [DataW-1:0] data,
                                          logic [TimeW-1:0] stamp_now);
    req_item_t item;
    item.kind         = kind;
    item.key          = key;
    item.data_in      = data;
    item.current_time = stamp_now;
    return item;
  endfunction

  function automatic logic [KeyW-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // Send one request: idle at random, hold valid until the transfer, then
  // record the predicted response. Valid stays high on return so that a
  // following request can go out back to back.
  task automatic send_request(input req_item_t item);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      req_if.valid = 1'b0;
      req_if.data  = make_item(op_kind_e'($urandom_range(3)), rand_key(), $urandom,
                               $urandom);
    end
    @(negedge clk);
    req_if.valid = 1'b1;
    req_if.data  = item;
    do @(posedge clk); while (!req_if.ready);
    pending_rsp.push_back(cache_predict(item));
    if (item.kind == OP_INSERT) begin
      live_keys.push_back(item.key);
      if (live_keys.size() > PoolDepth) void'(live_keys.pop_front());
    end
  endtask

  // Drop valid and hold off until every predicted response has arrived.
  task automatic wait_drained();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // Write the expiry register; only done with the block idle.
  task automatic write_expiry(input logic [ExpW-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.data  = cfg_item_t'(value);
    do @(posedge clk); while (!cfg_if.ready);
    expiry_limit = value;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Response checker: compare each response transfer with the oldest
  // prediction, field by field.
  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      rsp_seen = rsp_if.data;
      if (pending_rsp.size() == 0) begin
        error_count++;
        $display("%0t: unexpected response, expected none, actual status %0d data %h count %0d",
                 $time, rsp_seen.status, rsp_seen.data_out, rsp_seen.removed_count);
      end else begin
        rsp_want = pending_rsp.pop_front();
        if (rsp_seen.status !== rsp_want.status) begin
          error_count++;
          $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                   rsp_want.status, rsp_seen.status);
        end
        if (rsp_seen.data_out !== rsp_want.data_out) begin
          error_count++;
          $display("%0t: data_out mismatch, expected %h, actual %h", $time,
                   rsp_want.data_out, rsp_seen.data_out);
        end
        if (rsp_seen.removed_count !== rsp_want.removed_count) begin
          error_count++;
          $display("%0t: removed_count mismatch, expected %0d, actual %0d", $time,
                   rsp_want.removed_count, rsp_seen.removed_count);
        end
      end
    end
  end

  // Directed sequence on the reset expiry of 60: empty-table lookup and
  // purge, key and data extremes, a near-miss key, duplicate keys resolving
  // to the lowest slot, aging across the 32-bit wrap, the age-equals-expiry
  // boundary, reuse of the lowest freed slot, and ignored fields.
  task automatic test_directed();
    send_request(make_item(OP_LOOKUP, '0, '1, 32'h0));
    send_request(make_item(OP_PURGE, '1, '1, 32'h0));
    send_request(make_item(OP_INSERT, '0, '0, 32'hFFFF_FFF0));
    send_request(make_item(OP_INSERT, '1, '1, 32'hFFFF_FFF0));
    send_request(make_item(OP_INSERT, 64'h5555_5555_5555_5555, 32'hA5A5_A5A5, 32'd10));
    send_request(make_item(OP_LOOKUP, '1, '0, 32'hFFFF_FFF8));
    send_request(make_item(OP_LOOKUP, '0, '1, 32'hFFFF_FFF8));
    send_request(make_item(OP_LOOKUP, 64'h8000_0000_0000_0000, '0, 32'd12));
    send_request(make_item(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, '0, 32'd12));
    send_request(make_item(OP_INSERT, '0, 32'h1234_5678, 32'd20));
    send_request(make_item(OP_LOOKUP, '0, '0, 32'd21));
    // Ages at 80: the slots at 88 and 70 go; the refreshed one at 59 and the
    // duplicate at exactly 60 stay.
    send_request(make_item(OP_PURGE, rand_key(), $urandom, 32'd80));
    send_request(make_item(OP_LOOKUP, '0, '0, 32'd80));
    send_request(make_item(OP_INSERT, 64'd1, 32'h0F0F_0F0F, 32'd81));
    send_request(make_item(OP_PURGE, '0, '0, 32'd81));
    send_request(make_item(OP_LOOKUP, 64'd1, $urandom, 32'd81));
    send_request(make_item(OP_INVALIDATE, rand_key(), $urandom, $urandom));
    send_request(make_item(OP_LOOKUP, 64'd1, '0, 32'd82));
    send_request(make_item(OP_PURGE, '0, '0, 32'hFFFF_FFFF));
  endtask

  // Expiry extremes: zero removes anything older than the current stamp,
  // the maximum removes only ages of 2^31 and above, unsigned across the wrap.
  task automatic test_expiry_extremes();
    write_expiry('0);
    send_request(make_item(OP_INSERT, rand_key(), $urandom, 32'd100));
    send_request(make_item(OP_PURGE, '0, '0, 32'd100));
    send_request(make_item(OP_PURGE, '0, '0, 32'd101));
    write_expiry('1);
    send_request(make_item(OP_INSERT, rand_key(), $urandom, 32'd5));
    send_request(make_item(OP_PURGE, '0, '0, 32'h8000_0004));
    send_request(make_item(OP_PURGE, '0, '0, 32'h8000_0005));
    send_request(make_item(OP_INSERT, rand_key(), $urandom, 32'hFFFF_FFFF));
    send_request(make_item(OP_PURGE, '0, '0, 32'hFFFF_FFFE));
  endtask

  // Fill every slot, overflow once, then purge the whole table in one go
  // so that removed_count reaches the table size.
  task automatic test_table_full();
    logic [KeyW-1:0] first_key;
    int              i;
    write_expiry(ExpW'(1000));
    send_request(make_item(OP_INVALIDATE, '0, '0, '0));
    first_key = rand_key();
    send_request(make_item(OP_INSERT, first_key, $urandom, 32'd7));
    for (i = 1; i < Entries; i++) begin
      send_request(make_item(OP_INSERT, rand_key(), $urandom, 32'd7 + i));
    end
    send_request(make_item(OP_INSERT, rand_key(), $urandom, 32'd200));
    send_request(make_item(OP_LOOKUP, live_keys[live_keys.size()-2], '0, 32'd201));
    send_request(make_item(OP_LOOKUP, first_key, '0, 32'd202));
    send_request(make_item(OP_PURGE, '0, '0, 32'd2000));
    send_request(make_item(OP_INSERT, first_key, '1, 32'd2001));
    send_request(make_item(OP_LOOKUP, first_key, '0, 32'd2002));
  endtask

  // Random traffic: mostly lookups aimed at live keys and inserts, with
  // purges and invalidates mixed in and some fully random noise. Pause once
  // in the middle until the table is idle.
  task automatic test_random_traffic(input int unsigned count,
                                     input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input logic [ExpW-1:0] expiry,
                                     input int unsigned span);
    req_item_t        item;
    logic [KeyW-1:0]  key;
    logic [DataW-1:0] data_word;
    int unsigned      pick;
    int unsigned      sel;
    int unsigned      n;
    write_expiry(expiry);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    for (n = 0; n < count; n++) begin
      if (n == count / 2) wait_drained();
      if ($urandom_range(9) == 0) now_s += $urandom;
      else now_s += $urandom_range(span);
      data_word = ($urandom_range(7) == 0) ? ($urandom_range(1) ? '1 : '0) : $urandom;
      sel  = $urandom_range(99);
      pick = $urandom_range(99);
      if (pick < 40) begin
        if (live_keys.size() != 0 && sel < 65) begin
          key = live_keys[$urandom_range(live_keys.size() - 1)];
        end else if (live_keys.size() != 0 && sel < 80) begin
          key = live_keys[$urandom_range(live_keys.size() - 1)] ^
                (64'd1 << $urandom_range(KeyW - 1));
        end else begin
          key = rand_key();
        end
        item = make_item(OP_LOOKUP, key, data_word, now_s);
      end else if (pick < 75) begin
        if (live_keys.size() != 0 && sel < 20) begin
          key = live_keys[$urandom_range(live_keys.size() - 1)];
        end else if (sel < 28) begin
          key = $urandom_range(1) ? '1 : '0;
        end else begin
          key = rand_key();
        end
        item = make_item(OP_INSERT, key, data_word, now_s);
      end else if (pick < 93) begin
        item = make_item(OP_PURGE, rand_key(), data_word, now_s);
      end else if (pick < 97) begin
        item = make_item(OP_INVALIDATE, rand_key(), data_word, now_s);
      end else begin
        item = make_item(op_kind_e'($urandom_range(3)), rand_key(), $urandom, $urandom);
      end
      send_request(item);
    end
  endtask

  initial begin
    int i;
    // Drive every input to a known value before the first edge.
    rst_n           = 1'b0;
    req_if.valid    = 1'b0;
    req_if.data     = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = '0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    error_count     = 0;
    now_s           = '0;
    expiry_limit    = ExpReset;
    slot_count      = 0;
    for (i = 0; i < Entries; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i]   = '0;
      slot_data[i]  = '0;
      slot_stamp[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_expiry_extremes();
    test_table_full();
    test_random_traffic(340, 0, 0, ExpReset, 40);
    test_random_traffic(340, 78, 0, '0, 3);
    test_random_traffic(340, 0, 78, ExpW'($urandom_range(16, 400)), 60);
    test_random_traffic(340, 20, 20, '1, 40);

    // Drain, then give stray responses time to show up.
    wait_drained();
    repeat (Entries + 8) @(posedge clk);
    if (error_count == 0 && pending_rsp.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/emc_pkg.sv
sv/emc_stream_if.sv
sv/emc_entry_store.sv
sv/exact_match_cache_with_aging.sv
tb/sv/testbench.sv
